// ===== rtl/core/fmao_pkg.sv =====
package fmao_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 24;
  localparam int unsigned MAX_COLUMNS_DEF = 4096;

  localparam int unsigned COL_W   = 12;
  localparam int unsigned CNT_OUT_W = 24;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W  = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTPUT_MODE         = 3'd0,
    CFG_THRESHOLD_MODE      = 3'd1,
    CFG_INTENSITY_THRESHOLD = 3'd2,
    CFG_ANAT_LOW            = 3'd3,
    CFG_ANAT_GAIN           = 3'd4,
    CFG_FMRI_THRESHOLD      = 3'd5,
    CFG_FMRI_GAIN           = 3'd6,
    CFG_MIDPOINT_COLUMN     = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OMODE_GRAY56  = 2'd0,
    OMODE_GRAY192 = 2'd1,
    OMODE_GRAY238 = 2'd2
  } out_mode_t;

  typedef enum logic [1:0] {
    HIT_NONE = 2'd0,
    HIT_POS  = 2'd1,
    HIT_NEG  = 2'd2
  } hit_class_t;

  localparam int unsigned TMODE_POS_BIT = 0;
  localparam int unsigned TMODE_NEG_BIT = 1;

  typedef struct packed {
    logic [1:0]         output_mode;
    logic [1:0]         threshold_mode;
    logic [7:0]         intensity_threshold;
    logic signed [15:0] anat_low;
    logic [23:0]        anat_gain;
    logic [14:0]        fmri_threshold;
    logic [23:0]        fmri_gain;
    logic [COL_W-1:0]   midpoint_column;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] anat_sample;
    logic signed [15:0] fmri_value;
    logic [COL_W-1:0]   column;
    logic               first_voxel;
  } in_req_t;

  typedef struct packed {
    logic [7:0]           pixel_index;
    hit_class_t           hit_class;
    logic [CNT_OUT_W-1:0] pos_left_count;
    logic [CNT_OUT_W-1:0] pos_right_count;
    logic [CNT_OUT_W-1:0] neg_left_count;
    logic [CNT_OUT_W-1:0] neg_right_count;
  } out_req_t;

  // products and decisions handed from the multiply stage to the map stage
  typedef struct packed {
    logic [PROD_W-1:0] gray_prod;
    logic              diff_pos;
    logic [PROD_W-1:0] fmri_prod;
    logic              pos_hit;
    logic              neg_hit;
    logic              left;
    logic              first_voxel;
  } mid_req_t;

  typedef struct packed {
    logic [7:0] gray_top;
    logic [7:0] c_low;
    logic [7:0] c_mid;
    logic [7:0] c_top;
  } palette_t;

  function automatic palette_t palette_of(input logic [1:0] mode);
    palette_t p;
    unique case (mode)
      OMODE_GRAY192: p = '{gray_top: 8'd191, c_low: 8'd192, c_mid: 8'd224, c_top: 8'd255};
      OMODE_GRAY238: p = '{gray_top: 8'd237, c_low: 8'd238, c_mid: 8'd247, c_top: 8'd255};
      default:       p = '{gray_top: 8'd55,  c_low: 8'd56,  c_mid: 8'd60,  c_top: 8'd63};
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/fmao_cfg_regs.sv =====
module fmao_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fmao_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fmao_pkg::CFG_W-1:0]       cfg_data,
  output fmao_pkg::cfg_t                   cfg
);

  fmao_pkg::cfg_t cfg_r;
  fmao_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (fmao_pkg::cfg_idx_t'(cfg_index))
        fmao_pkg::CFG_OUTPUT_MODE:         cfg_nxt.output_mode = cfg_data[1:0];
        fmao_pkg::CFG_THRESHOLD_MODE:      cfg_nxt.threshold_mode = cfg_data[1:0];
        fmao_pkg::CFG_INTENSITY_THRESHOLD: cfg_nxt.intensity_threshold = cfg_data[7:0];
        fmao_pkg::CFG_ANAT_LOW:            cfg_nxt.anat_low = $signed(cfg_data[15:0]);
        fmao_pkg::CFG_ANAT_GAIN:           cfg_nxt.anat_gain = cfg_data[23:0];
        fmao_pkg::CFG_FMRI_THRESHOLD:      cfg_nxt.fmri_threshold = cfg_data[14:0];
        fmao_pkg::CFG_FMRI_GAIN:           cfg_nxt.fmri_gain = cfg_data[23:0];
        fmao_pkg::CFG_MIDPOINT_COLUMN:     cfg_nxt.midpoint_column = cfg_data[11:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.output_mode         <= fmao_pkg::OMODE_GRAY56;
      cfg_r.threshold_mode      <= 2'd1;
      cfg_r.intensity_threshold <= 8'd5;
      cfg_r.anat_low            <= 16'sd0;
      cfg_r.anat_gain           <= 24'd65536;
      cfg_r.fmri_threshold      <= 15'd0;
      cfg_r.fmri_gain           <= 24'd65536;
      cfg_r.midpoint_column     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/fmao_front.sv =====
module fmao_front #(
  parameter int unsigned MAX_COLUMNS = fmao_pkg::MAX_COLUMNS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  fmao_pkg::in_req_t    in_data,
  input  fmao_pkg::cfg_t       cfg,
  output logic                 s2_valid,
  output fmao_pkg::mid_req_t   s2_data
);

  localparam logic [16:0] LAST_COL = 17'(MAX_COLUMNS - 1);

  logic                s1_valid_r;
  fmao_pkg::in_req_t   s1_r;
  logic                s2_valid_r;
  fmao_pkg::mid_req_t  s2_r;
  fmao_pkg::mid_req_t  s2_nxt;

  logic signed [16:0]  diff;
  logic                fm_pos;
  logic                fm_neg;
  logic [15:0]         mag;
  logic                mag_ok;
  logic [15:0]         excess;
  logic [16:0]         col_ext;
  logic [16:0]         col_c;

  always_comb begin
    diff    = {s1_r.anat_sample[15], s1_r.anat_sample} - {cfg.anat_low[15], cfg.anat_low};
    fm_pos  = !s1_r.fmri_value[15] && (s1_r.fmri_value != 16'sd0);
    fm_neg  = s1_r.fmri_value[15];
    mag     = fm_neg ? (~s1_r.fmri_value + 16'd1) : s1_r.fmri_value;
    mag_ok  = mag >= {1'b0, cfg.fmri_threshold};
    excess  = mag - {1'b0, cfg.fmri_threshold};
    col_ext = {5'd0, s1_r.column};
    col_c   = (col_ext > LAST_COL) ? LAST_COL : col_ext;

    s2_nxt.gray_prod   = {24'd0, diff[15:0]} * {16'd0, cfg.anat_gain};
    s2_nxt.diff_pos    = !diff[16] && (diff != 17'sd0);
    s2_nxt.fmri_prod   = {24'd0, excess} * {16'd0, cfg.fmri_gain};
    s2_nxt.pos_hit     = fm_pos && cfg.threshold_mode[fmao_pkg::TMODE_POS_BIT] && mag_ok;
    s2_nxt.neg_hit     = fm_neg && cfg.threshold_mode[fmao_pkg::TMODE_NEG_BIT] && mag_ok;
    s2_nxt.left        = col_c < {5'd0, cfg.midpoint_column};
    s2_nxt.first_voxel = s1_r.first_voxel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= in_data;
      s2_r <= s2_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_data  = s2_r;

endmodule

// ===== rtl/core/fmao_back.sv =====
module fmao_back #(
  parameter int unsigned COUNT_WIDTH = fmao_pkg::COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 s2_valid,
  input  fmao_pkg::mid_req_t   s2_data,
  input  fmao_pkg::cfg_t       cfg,
  output logic                 out_valid,
  output fmao_pkg::out_req_t   out_data
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  fmao_pkg::palette_t  pal;
  logic [23:0]         g;
  logic [7:0]          gray;
  logic                overlay;
  logic [40:0]         pos_sum;
  logic [17:0]         pos_v;
  logic [7:0]          pos_pix;
  logic signed [41:0]  neg_v;
  logic signed [41:0]  neg_low;
  logic [17:0]         neg_t;
  logic [7:0]          mid_m1;
  logic [7:0]          neg_pix;
  logic                do_pos;
  logic                do_neg;
  logic                clr;

  logic [COUNT_WIDTH-1:0] pl_r, pr_r, nl_r, nr_r;
  logic [COUNT_WIDTH-1:0] pl_nxt, pr_nxt, nl_nxt, nr_nxt;
  logic                   out_valid_r;
  fmao_pkg::out_req_t     out_r;
  fmao_pkg::out_req_t     out_nxt;

  always_comb begin
    pal     = fmao_pkg::palette_of(cfg.output_mode);
    g       = s2_data.gray_prod[39:16];
    if (!s2_data.diff_pos) begin
      gray = 8'd0;
    end else if (g > {16'd0, pal.gray_top}) begin
      gray = pal.gray_top;
    end else begin
      gray = g[7:0];
    end
    overlay = gray >= cfg.intensity_threshold;

    pos_sum = {1'b0, s2_data.fmri_prod} + 41'h800000;
    pos_v   = {10'd0, pal.c_mid} + {1'b0, pos_sum[40:24]};
    pos_pix = (pos_v > {10'd0, pal.c_top}) ? pal.c_top : pos_v[7:0];

    neg_v   = $signed({10'd0, pal.c_mid, 24'h800000}) - $signed({2'b00, s2_data.fmri_prod});
    neg_low = $signed({10'd0, pal.c_low, 24'd0});
    neg_t   = neg_v[41:24];
    mid_m1  = pal.c_mid - 8'd1;
    if (neg_v < neg_low) begin
      neg_pix = pal.c_low;
    end else if (neg_t > {10'd0, mid_m1}) begin
      neg_pix = mid_m1;
    end else begin
      neg_pix = neg_t[7:0];
    end

    do_pos = overlay && s2_data.pos_hit;
    do_neg = overlay && s2_data.neg_hit && !s2_data.pos_hit;
    clr    = s2_data.first_voxel;

    pl_nxt = clr ? '0 : pl_r;
    pr_nxt = clr ? '0 : pr_r;
    nl_nxt = clr ? '0 : nl_r;
    nr_nxt = clr ? '0 : nr_r;
    if (do_pos) begin
      if (s2_data.left) begin
        if (pl_nxt != CNT_MAX) pl_nxt = pl_nxt + CNT_ONE;
      end else begin
        if (pr_nxt != CNT_MAX) pr_nxt = pr_nxt + CNT_ONE;
      end
    end else if (do_neg) begin
      if (s2_data.left) begin
        if (nl_nxt != CNT_MAX) nl_nxt = nl_nxt + CNT_ONE;
      end else begin
        if (nr_nxt != CNT_MAX) nr_nxt = nr_nxt + CNT_ONE;
      end
    end

    priority if (do_pos) begin
      out_nxt.pixel_index = pos_pix;
      out_nxt.hit_class   = fmao_pkg::HIT_POS;
    end else if (do_neg) begin
      out_nxt.pixel_index = neg_pix;
      out_nxt.hit_class   = fmao_pkg::HIT_NEG;
    end else begin
      out_nxt.pixel_index = gray;
      out_nxt.hit_class   = fmao_pkg::HIT_NONE;
    end
    out_nxt.pos_left_count  = fmao_pkg::CNT_OUT_W'(pl_nxt);
    out_nxt.pos_right_count = fmao_pkg::CNT_OUT_W'(pr_nxt);
    out_nxt.neg_left_count  = fmao_pkg::CNT_OUT_W'(nl_nxt);
    out_nxt.neg_right_count = fmao_pkg::CNT_OUT_W'(nr_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pl_r        <= '0;
      pr_r        <= '0;
      nl_r        <= '0;
      nr_r        <= '0;
    end else if (adv) begin
      out_valid_r <= s2_valid;
      if (s2_valid) begin
        pl_r <= pl_nxt;
        pr_r <= pr_nxt;
        nl_r <= nl_nxt;
        nr_r <= nr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // without a clear, one request moves at most one counter
  a_one_counter: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_valid && !s2_data.first_voxel) |=>
      ($countones({pl_r != $past(pl_r), pr_r != $past(pr_r),
                   nl_r != $past(nl_r), nr_r != $past(nr_r)}) <= 1))
    else $error("more than one hit counter moved");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && s2_valid) |=>
      ($stable(pl_r) && $stable(pr_r) && $stable(nl_r) && $stable(nr_r)))
    else $error("hit counters moved without a request");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_valid) |=> out_valid_r)
    else $error("request lost at result register");

endmodule

// ===== rtl/core/fmri_anatomical_overlay_mapper.sv =====
// Pipeline: an accepted voxel passes the input, product and result registers in turn before result valid.
// Throughput: one voxel per cycle; the pipeline advances whenever the result register
//   is empty or its result is taken, so a stalled result holds every stage.
// Reset (rst_n low, synchronous): configuration to defaults, hit counters to zero,
//   all stage valids cleared.
module fmri_anatomical_overlay_mapper #(
  parameter int unsigned COUNT_WIDTH = fmao_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned MAX_COLUMNS = fmao_pkg::MAX_COLUMNS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  fmao_pkg::in_req_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output fmao_pkg::out_req_t               out_data,
  input  logic                             cfg_we,
  input  logic [fmao_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fmao_pkg::CFG_W-1:0]       cfg_data
);

  fmao_pkg::cfg_t      cfg;
  fmao_pkg::mid_req_t  s2_data;
  logic                s2_valid;
  logic                adv;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  fmao_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fmao_front #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cfg      (cfg),
    .s2_valid (s2_valid),
    .s2_data  (s2_data)
  );

  fmao_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s2_valid  (s2_valid),
    .s2_data   (s2_data),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== tb/fmri_anatomical_overlay_mapper_test.sv =====
module fmri_anatomical_overlay_mapper_test;
  import fmao_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int OMODE_UNDEFINED = 3;

  typedef enum logic [1:0] {
    STEP_VOXEL,
    STEP_WRITE,
    STEP_SETTLE
  } step_kind_t;

  typedef struct packed {
    step_kind_t       kind;
    in_req_t          voxel;
    cfg_idx_t         reg_idx;
    logic [CFG_W-1:0] reg_val;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_req_t out_data;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_OUTPUT_MODE;
  logic [CFG_W-1:0] cfg_data = '0;

  cfg_t regs = '{output_mode: OMODE_GRAY56, threshold_mode: 2'd1, intensity_threshold: 8'd5,
                 anat_low: 16'sd0, anat_gain: 24'd65536, fmri_threshold: 15'd0,
                 fmri_gain: 24'd65536, midpoint_column: '0};
  logic [CNT_OUT_W-1:0] pos_left = '0;
  logic [CNT_OUT_W-1:0] pos_right = '0;
  logic [CNT_OUT_W-1:0] neg_left = '0;
  logic [CNT_OUT_W-1:0] neg_right = '0;

  step_t feed_q[$];
  out_req_t predicted_pixels[$];
  int requests_taken = 0;
  int results_checked = 0;
  int errors = 0;
  int gap_left = 0;
  int send_burst = 0;
  int stall_left = 0;
  int stall_burst = 0;
  int settle_cnt = 0;

  fmri_anatomical_overlay_mapper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int idle_len(inout int burst);
    int roll;
    roll = $urandom_range(0, 99);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if (roll < 4) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic out_req_t map_voxel(input in_req_t v);
    out_req_t r;
    logic [7:0] gray_top, c_low, c_mid, c_top;
    int diff, fm;
    longint unsigned gray, scaled;
    longint level;
    logic on_left;
    if (v.first_voxel) begin
      pos_left = '0;
      pos_right = '0;
      neg_left = '0;
      neg_right = '0;
    end
    on_left = v.column < regs.midpoint_column;
    case (regs.output_mode)
      OMODE_GRAY192: begin
        gray_top = 8'd191; c_low = 8'd192; c_mid = 8'd224; c_top = 8'd255;
      end
      OMODE_GRAY238: begin
        gray_top = 8'd237; c_low = 8'd238; c_mid = 8'd247; c_top = 8'd255;
      end
      default: begin
        gray_top = 8'd55; c_low = 8'd56; c_mid = 8'd60; c_top = 8'd63;
      end
    endcase
    diff = int'($signed(v.anat_sample)) - int'($signed(regs.anat_low));
    if (diff <= 0) begin
      gray = 0;
    end else begin
      gray = (longint'(diff) * longint'(regs.anat_gain)) >> 16;
      if (gray > gray_top) gray = gray_top;
    end
    r.pixel_index = gray[7:0];
    r.hit_class = HIT_NONE;
    fm = int'($signed(v.fmri_value));
    if (gray >= regs.intensity_threshold) begin
      if (fm > 0 && regs.threshold_mode[TMODE_POS_BIT] &&
          fm >= int'(regs.fmri_threshold)) begin
        scaled = longint'(fm - int'(regs.fmri_threshold)) * longint'(regs.fmri_gain);
        scaled = ((scaled + 64'd8388608) >> 24) + c_mid;
        r.pixel_index = (scaled > c_top) ? c_top : scaled[7:0];
        r.hit_class = HIT_POS;
        if (on_left) begin
          if (pos_left != '1) pos_left++;
        end else begin
          if (pos_right != '1) pos_right++;
        end
      end else if (fm < 0 && regs.threshold_mode[TMODE_NEG_BIT] &&
                   -fm >= int'(regs.fmri_threshold)) begin
        level = longint'(c_mid) * 64'sd16777216 + 64'sd8388608
                - longint'(-fm - int'(regs.fmri_threshold)) * longint'(regs.fmri_gain);
        if (level < longint'(c_low) * 64'sd16777216) r.pixel_index = c_low;
        else if ((level >>> 24) > longint'(c_mid) - 1) r.pixel_index = c_mid - 8'd1;
        else r.pixel_index = level[31:24];
        r.hit_class = HIT_NEG;
        if (on_left) begin
          if (neg_left != '1) neg_left++;
        end else begin
          if (neg_right != '1) neg_right++;
        end
      end
    end
    r.pos_left_count = pos_left;
    r.pos_right_count = pos_right;
    r.neg_left_count = neg_left;
    r.neg_right_count = neg_right;
    return r;
  endfunction

  function automatic void voxel(input int anat, input int fmri, input int col, input bit first);
    step_t s;
    s = '0;
    s.kind = STEP_VOXEL;
    s.voxel.anat_sample = anat[15:0];
    s.voxel.fmri_value = fmri[15:0];
    s.voxel.column = col[COL_W-1:0];
    s.voxel.first_voxel = first;
    feed_q.push_back(s);
  endfunction

  function automatic void set_reg(input cfg_idx_t idx, input int val);
    step_t s;
    s = '0;
    s.kind = STEP_WRITE;
    s.reg_idx = idx;
    s.reg_val = val[CFG_W-1:0];
    feed_q.push_back(s);
  endfunction

  function automatic void settle();
    step_t s;
    s = '0;
    s.kind = STEP_SETTLE;
    feed_q.push_back(s);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // request driver; register writes only go out after a settle step
  always @(posedge clk) begin : driver
    step_t step;
    logic drive_valid;
    logic drive_we;
    drive_we = 1'b0;
    drive_valid = in_valid;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted_pixels.push_back(map_voxel(in_data));
        requests_taken++;
        drive_valid = 1'b0;
      end
      if (!drive_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (feed_q.size() > 0) begin
          step = feed_q[0];
          case (step.kind)
            STEP_VOXEL: begin
              drive_valid = 1'b1;
              in_data <= step.voxel;
              void'(feed_q.pop_front());
              gap_left = idle_len(send_burst);
            end
            STEP_WRITE: begin
              drive_we = 1'b1;
              cfg_index <= step.reg_idx;
              cfg_data <= step.reg_val;
              case (step.reg_idx)
                CFG_OUTPUT_MODE:         regs.output_mode = step.reg_val[1:0];
                CFG_THRESHOLD_MODE:      regs.threshold_mode = step.reg_val[1:0];
                CFG_INTENSITY_THRESHOLD: regs.intensity_threshold = step.reg_val[7:0];
                CFG_ANAT_LOW:            regs.anat_low = step.reg_val[15:0];
                CFG_ANAT_GAIN:           regs.anat_gain = step.reg_val[23:0];
                CFG_FMRI_THRESHOLD:      regs.fmri_threshold = step.reg_val[14:0];
                CFG_FMRI_GAIN:           regs.fmri_gain = step.reg_val[23:0];
                CFG_MIDPOINT_COLUMN:     regs.midpoint_column = step.reg_val[COL_W-1:0];
                default: ;
              endcase
              void'(feed_q.pop_front());
            end
            default: begin
              if (requests_taken == results_checked) begin
                if (settle_cnt == SETTLE_CYCLES) begin
                  settle_cnt = 0;
                  void'(feed_q.pop_front());
                end else begin
                  settle_cnt++;
                end
              end else begin
                settle_cnt = 0;
              end
            end
          endcase
        end
      end
    end
    in_valid <= drive_valid;
    cfg_we <= drive_we;
  end

  always @(posedge clk) begin : monitor
    out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked <= results_checked + 1;
      if (predicted_pixels.size() == 0) begin
        $error("unexpected result: pixel_index %0d", out_data.pixel_index);
        errors++;
      end else begin
        want = predicted_pixels.pop_front();
        check_field("pixel_index", want.pixel_index, out_data.pixel_index);
        check_field("hit_class", want.hit_class, out_data.hit_class);
        check_field("pos_left_count", want.pos_left_count, out_data.pos_left_count);
        check_field("pos_right_count", want.pos_right_count, out_data.pos_right_count);
        check_field("neg_left_count", want.neg_left_count, out_data.neg_left_count);
        check_field("neg_right_count", want.neg_right_count, out_data.neg_right_count);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = idle_len(stall_burst);
    end
  end

  initial begin : stimulus
    int anat, fmri, col, val, roll, items;
    int low_now, thr_now, mid_now, settings;
    settings = 1;

    // defaults after reset
    voxel(10, 256, 0, 1'b1);
    voxel(-1, 32767, 4095, 1'b0);

    settle();
    set_reg(CFG_OUTPUT_MODE, OMODE_GRAY192);
    set_reg(CFG_THRESHOLD_MODE, 3);
    set_reg(CFG_INTENSITY_THRESHOLD, 10);
    set_reg(CFG_ANAT_LOW, -100);
    set_reg(CFG_ANAT_GAIN, 65536);
    set_reg(CFG_FMRI_THRESHOLD, 256);
    set_reg(CFG_FMRI_GAIN, 24'h100000);
    set_reg(CFG_MIDPOINT_COLUMN, 2048);
    settings++;
    voxel(-32768, 32767, 0, 1'b1);
    voxel(-100, 32767, 1, 1'b0);
    voxel(32767, 32767, 4095, 1'b0);
    voxel(100, -32768, 0, 1'b0);
    voxel(50, 0, 2047, 1'b0);
    voxel(50, 256, 2048, 1'b0);
    voxel(50, -256, 2047, 1'b0);
    voxel(50, 255, 10, 1'b0);
    voxel(50, 264, 3000, 1'b0);
    voxel(50, -280, 100, 1'b0);
    voxel(-90, 512, 2048, 1'b0);
    voxel(-91, 32767, 2048, 1'b0);
    voxel(0, 300, 5, 1'b1);

    // undefined palette code, overlay disabled
    settle();
    set_reg(CFG_OUTPUT_MODE, OMODE_UNDEFINED);
    set_reg(CFG_THRESHOLD_MODE, 0);
    set_reg(CFG_INTENSITY_THRESHOLD, 0);
    settings++;
    voxel(200, 1000, 7, 1'b0);
    settle();
    set_reg(CFG_THRESHOLD_MODE, 3);
    set_reg(CFG_INTENSITY_THRESHOLD, 56);
    settings++;
    voxel(32767, 1000, 7, 1'b0);
    voxel(32767, -1000, 7, 1'b0);

    settle();
    set_reg(CFG_OUTPUT_MODE, OMODE_GRAY238);
    set_reg(CFG_THRESHOLD_MODE, 2);
    set_reg(CFG_INTENSITY_THRESHOLD, 0);
    settings++;
    voxel(300, -32768, 0, 1'b0);
    voxel(300, 32767, 4095, 1'b0);
    voxel(300, -300, 3000, 1'b0);

    // phase 0: every register low, phase 1: every register high, then random
    for (int p = 0; p < 11; p++) begin
      settle();
      settings++;
      low_now = 0;
      thr_now = 0;
      mid_now = 0;
      for (int i = 0; i < 8; i++) begin
        roll = $urandom_range(0, 99);
        case (cfg_idx_t'(i))
          CFG_OUTPUT_MODE:
            val = (p == 0) ? OMODE_GRAY56 : (p == 1) ? OMODE_GRAY238 : $urandom_range(0, 3);
          CFG_THRESHOLD_MODE:
            val = (p == 0) ? 0 : (p == 1) ? 3 : (roll < 10) ? 0 : $urandom_range(1, 3);
          CFG_INTENSITY_THRESHOLD:
            val = (p == 0) ? 0 : (p == 1) ? 255 : (roll < 5) ? 255 : (roll < 15) ? 0 :
                  $urandom_range(0, 40);
          CFG_ANAT_LOW: begin
            val = (p == 0) ? -32768 : (p == 1) ? 32767 : (roll < 8) ? -32768 :
                  (roll < 15) ? 32767 : int'($urandom_range(0, 2000)) - 1000;
            low_now = val;
          end
          CFG_ANAT_GAIN:
            val = (p == 0) ? 0 : (p == 1) ? 24'hFFFFFF : (roll < 7) ? 0 :
                  (roll < 15) ? 24'hFFFFFF : $urandom_range(1 << 12, 1 << 19);
          CFG_FMRI_THRESHOLD: begin
            val = (p == 0) ? 0 : (p == 1) ? 15'h7FFF : (roll < 5) ? 15'h7FFF :
                  (roll < 12) ? 0 : $urandom_range(0, 2048);
            thr_now = val;
          end
          CFG_FMRI_GAIN:
            val = (p == 0) ? 0 : (p == 1) ? 24'hFFFFFF : (roll < 5) ? 0 :
                  (roll < 12) ? 24'hFFFFFF : $urandom_range(1 << 12, 1 << 22);
          default: begin
            val = (p == 0) ? 0 : (p == 1) ? 4095 : $urandom_range(0, 4095);
            mid_now = val;
          end
        endcase
        set_reg(cfg_idx_t'(i), val);
      end
      items = (p < 2) ? 20 : 55;
      for (int n = 0; n < items; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 30) anat = int'($signed(16'($urandom)));
        else if (roll < 65) anat = low_now + int'($urandom_range(0, 300)) - 20;
        else anat = low_now + int'($urandom_range(0, 6000)) - 200;
        if (anat > 32767) anat = 32767;
        if (anat < -32768) anat = -32768;
        roll = $urandom_range(0, 99);
        if (roll < 25) fmri = int'($signed(16'($urandom)));
        else if (roll < 85) fmri = thr_now + int'($urandom_range(0, 2048));
        else fmri = thr_now + int'($urandom_range(0, 16)) - 8;
        if (roll >= 25 && $urandom_range(0, 1) == 1) fmri = -fmri;
        if (fmri > 32767) fmri = 32767;
        if (fmri < -32768) fmri = -32768;
        roll = $urandom_range(0, 99);
        if (roll < 5) col = (mid_now > 0) ? mid_now - 1 : 0;
        else if (roll < 10) col = mid_now;
        else col = $urandom_range(0, 4095);
        voxel(anat, fmri, col, $urandom_range(0, 99) < 3);
      end
    end
    settle();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (feed_q.size() > 0) @(posedge clk);

    $display("%0d voxels checked under %0d register settings", requests_taken, settings);
    $display("directed corners first, then random requests with gaps and stalls");
    if (errors == 0 && predicted_pixels.size() == 0) begin
      $display("fmri_anatomical_overlay_mapper_test: done, clean");
    end else begin
      if (predicted_pixels.size() != 0)
        $error("%0d expected results never arrived", predicted_pixels.size());
      $display("fmri_anatomical_overlay_mapper_test: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #3200000;
    $display("fmri_anatomical_overlay_mapper_test: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fmao_pkg.sv
rtl/core/fmao_cfg_regs.sv
rtl/core/fmao_front.sv
rtl/core/fmao_back.sv
rtl/core/fmri_anatomical_overlay_mapper.sv
tb/fmri_anatomical_overlay_mapper_test.sv
